// ===== rtl/kte_pkg.sv =====
// shared types, constants and codes of the keyframe track evaluator
package kte_pkg;

    localparam int EVENT_DEPTH = 256;
    localparam int FRAC_BITS   = 16;

    localparam int IDX_W  = (EVENT_DEPTH > 1) ? $clog2(EVENT_DEPTH) : 1;
    localparam int ADDR_W = IDX_W + 2;
    localparam int CNT_W  = 9;
    localparam int SCAN_W = (IDX_W + 1 > CNT_W) ? IDX_W + 1 : CNT_W;
    localparam int RES_W  = 66;
    localparam int OPB_W  = 33;
    localparam int STEP_W = $clog2(RES_W);
    localparam int CFG_IDX_W = 3;

    localparam logic [31:0] BPM_RESET  = 32'(120 << FRAC_BITS);
    localparam logic [31:0] TDIV_RESET = 32'(15 << (FRAC_BITS - 3));

    localparam logic [CFG_IDX_W-1:0] CFG_BPM        = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TDIV       = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MOVE_CNT   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_ROTATE_CNT = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_ALPHA_CNT  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_SPEED_CNT  = 3'd5;

    localparam logic [1:0] CH_MOVE   = 2'd0;
    localparam logic [1:0] CH_ROTATE = 2'd1;
    localparam logic [1:0] CH_ALPHA  = 2'd2;
    localparam logic [1:0] CH_SPEED  = 2'd3;

    localparam logic ACT_WRITE = 1'b0;
    localparam logic ACT_QUERY = 1'b1;

    typedef struct packed {
        logic              action;
        logic [1:0]        channel;
        logic [7:0]        event_index;
        logic [31:0]       start_tick;
        logic [31:0]       end_tick;
        logic signed [31:0] start_value;
        logic signed [31:0] end_value;
        logic signed [31:0] start_value_second;
        logic signed [31:0] end_value_second;
        logic [31:0]       query_seconds;
    } kte_in_t;

    typedef struct packed {
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic signed [31:0] rotation;
        logic signed [31:0] alpha;
        logic signed [31:0] floor_position;
        logic signed [31:0] speed;
    } kte_out_t;

    typedef enum logic [4:0] {
        ST_IDLE, ST_DISPATCH, ST_WR,
        ST_SP_MUL, ST_SP_MUL_W, ST_SP_DIV, ST_SP_DIV_W, ST_SP_MUL2, ST_SP_MUL2_W, ST_SP_FIN,
        ST_Q_MUL, ST_Q_MUL_W, ST_Q_DIV, ST_Q_DIV_W, ST_Q_TICK,
        ST_SC_INIT, ST_SC_CHK, ST_SC_CMP,
        ST_LP_MUL, ST_LP_MUL_W, ST_LP_DIV, ST_LP_DIV_W, ST_LP_FIN,
        ST_Q_OUT
    } kte_state_t;

    typedef enum logic { UOP_MUL, UOP_DIV } kte_uop_t;

    typedef enum logic [2:0] {
        OPS_SP_MUL, OPS_SP_DIV, OPS_SP_MUL2, OPS_Q_MUL, OPS_Q_DIV, OPS_LP_MUL, OPS_LP_DIV
    } kte_opsel_t;

    typedef struct packed {
        logic       capture;
        logic       mem_wr;
        logic       sum_upd;
        logic       unit_start;
        kte_uop_t   uop;
        kte_opsel_t opsel;
        logic       tick_load;
        logic       scan_init;
        logic       scan_rd;
        logic       scan_adv;
        logic       cursor_upd;
        logic       lerp_fin;
        logic       out_load;
        logic [1:0] ch;
        logic       second;
    } kte_cmd_t;

    typedef struct packed {
        logic is_query;
        logic idx_ok;
        logic is_speed;
        logic unit_busy;
        logic unit_done;
        logic i_ge_n;
        logic found;
        logic out_busy;
    } kte_sts_t;

endpackage

// ===== rtl/kte_arith.sv =====
// shared bit-serial unsigned multiply and restoring divide unit
module kte_arith (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        start,
    input  kte_pkg::kte_uop_t           uop,
    input  logic [kte_pkg::RES_W-1:0]   opa,
    input  logic [kte_pkg::OPB_W-1:0]   opb,
    output logic                        busy,
    output logic                        done,
    output logic [kte_pkg::RES_W-1:0]   result
);
    logic                        busy_reg, done_reg;
    kte_pkg::kte_uop_t           uop_reg;
    logic [kte_pkg::STEP_W-1:0]  cnt_reg;
    logic [kte_pkg::RES_W-1:0]   acc_reg, x_reg;
    logic [kte_pkg::OPB_W-1:0]   y_reg, rem_reg;

    logic [kte_pkg::RES_W-1:0]   acc_next;
    logic [kte_pkg::OPB_W:0]     trial, trial_sub;
    logic                        ge;
    logic [kte_pkg::OPB_W-1:0]   rem_next;
    logic                        last;

    always_comb begin
        acc_next  = y_reg[0] ? acc_reg + x_reg : acc_reg;
        trial     = {rem_reg, x_reg[kte_pkg::RES_W-1]};
        ge        = trial >= {1'b0, y_reg};
        trial_sub = trial - {1'b0, y_reg};
        rem_next  = ge ? trial_sub[kte_pkg::OPB_W-1:0] : trial[kte_pkg::OPB_W-1:0];
        last      = (uop_reg == kte_pkg::UOP_MUL) ?
                    (cnt_reg == kte_pkg::STEP_W'(kte_pkg::OPB_W - 1)) :
                    (cnt_reg == kte_pkg::STEP_W'(kte_pkg::RES_W - 1));
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
            end else if (busy_reg && last) begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            uop_reg <= uop;
            cnt_reg <= '0;
            acc_reg <= '0;
            rem_reg <= '0;
            x_reg   <= opa;
            y_reg   <= opb;
        end else if (busy_reg) begin
            cnt_reg <= cnt_reg + 1'b1;
            if (uop_reg == kte_pkg::UOP_MUL) begin
                acc_reg <= acc_next;
                x_reg   <= {x_reg[kte_pkg::RES_W-2:0], 1'b0};
                y_reg   <= {1'b0, y_reg[kte_pkg::OPB_W-1:1]};
            end else begin
                // quotient bits shift in where the dividend shifts out
                rem_reg <= rem_next;
                x_reg   <= {x_reg[kte_pkg::RES_W-2:0], ge};
            end
        end
    end

    assign busy   = busy_reg;
    assign done   = done_reg;
    assign result = (uop_reg == kte_pkg::UOP_MUL) ? acc_reg : x_reg;

endmodule

// ===== rtl/kte_dp.sv =====
// datapath: config registers, event tables, scan, interpolation and output register
module kte_dp (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  kte_pkg::kte_in_t                s_data,
    input  logic                            cfg_we,
    input  logic [kte_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [31:0]                     cfg_data,
    input  kte_pkg::kte_cmd_t               cmd,
    output kte_pkg::kte_sts_t               sts,
    output kte_pkg::kte_out_t               m_data,
    output logic                            m_valid,
    input  logic                            m_ready
);
    localparam int MEM_D = 4 * kte_pkg::EVENT_DEPTH;

    function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
        if (v > 64'sd2147483647)
            return 32'sh7FFFFFFF;
        else if (v < -64'sd2147483648)
            return 32'sh80000000;
        else
            return v[31:0];
    endfunction

    // configuration
    logic [31:0]               bpm_reg, td_reg;
    logic [kte_pkg::CNT_W-1:0] cnt_reg [4];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            bpm_reg <= kte_pkg::BPM_RESET;
            td_reg  <= kte_pkg::TDIV_RESET;
            for (int k = 0; k < 4; k++) cnt_reg[k] <= '0;
        end else if (cfg_we) begin
            case (cfg_index)
                kte_pkg::CFG_BPM:        bpm_reg    <= cfg_data;
                kte_pkg::CFG_TDIV:       td_reg     <= cfg_data;
                kte_pkg::CFG_MOVE_CNT:   cnt_reg[0] <= cfg_data[kte_pkg::CNT_W-1:0];
                kte_pkg::CFG_ROTATE_CNT: cnt_reg[1] <= cfg_data[kte_pkg::CNT_W-1:0];
                kte_pkg::CFG_ALPHA_CNT:  cnt_reg[2] <= cfg_data[kte_pkg::CNT_W-1:0];
                kte_pkg::CFG_SPEED_CNT:  cnt_reg[3] <= cfg_data[kte_pkg::CNT_W-1:0];
                default: ;
            endcase
        end
    end

    // captured item
    kte_pkg::kte_in_t in_reg;
    always_ff @(posedge aclk) begin
        if (cmd.capture) in_reg <= s_data;
    end

    // arithmetic unit
    logic [kte_pkg::RES_W-1:0] opa, unit_res;
    logic [kte_pkg::OPB_W-1:0] opb;
    logic                      unit_busy, unit_done;

    kte_arith u_arith (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (cmd.unit_start),
        .uop     (cmd.uop),
        .opa     (opa),
        .opb     (opb),
        .busy    (unit_busy),
        .done    (unit_done),
        .result  (unit_res)
    );

    // speed write: duration and floor step
    logic                d_neg;
    logic [31:0]         md, spd_mag, dmag, qlow;
    logic                q_big, neg_inc;
    logic signed [31:0]  sum_reg, sum_base, sum_new;
    logic [kte_pkg::RES_W-1:0] inc_sh;
    logic signed [63:0]  base64, inc64, sum_wide;

    always_comb begin
        d_neg   = in_reg.end_tick < in_reg.start_tick;
        md      = d_neg ? in_reg.start_tick - in_reg.end_tick
                        : in_reg.end_tick - in_reg.start_tick;
        spd_mag = in_reg.start_value[31] ? 32'(-in_reg.start_value) : in_reg.start_value;
        if (bpm_reg == '0) begin
            q_big = md != '0;
            qlow  = '0;
        end else begin
            q_big = |unit_res[kte_pkg::RES_W-1:31];
            qlow  = unit_res[31:0];
        end
        if (q_big)
            dmag = d_neg ? 32'h8000_0000 : 32'h7FFF_FFFF;
        else
            dmag = qlow;
        neg_inc  = in_reg.start_value[31] ^ d_neg;
        sum_base = (in_reg.event_index == '0) ? 32'sd0 : sum_reg;
        // magnitude shift truncates toward zero
        inc_sh   = unit_res >> kte_pkg::FRAC_BITS;
        base64   = {{32{sum_base[31]}}, sum_base};
        inc64    = {16'b0, inc_sh[47:0]};
        sum_wide = neg_inc ? base64 - inc64 : base64 + inc64;
        sum_new  = sat32(sum_wide);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) sum_reg <= '0;
        else if (cmd.sum_upd) sum_reg <= sum_new;
    end

    // event tables
    logic [31:0] st_mem  [MEM_D];
    logic [31:0] et_mem  [MEM_D];
    logic [31:0] sv_mem  [MEM_D];
    logic [31:0] ev_mem  [MEM_D];
    logic [31:0] sv2_mem [kte_pkg::EVENT_DEPTH];
    logic [31:0] ev2_mem [kte_pkg::EVENT_DEPTH];
    logic [31:0] spd_mem [kte_pkg::EVENT_DEPTH];

    logic [kte_pkg::IDX_W-1:0]  widx, ridx;
    logic [kte_pkg::ADDR_W-1:0] waddr, raddr;
    logic [kte_pkg::SCAN_W-1:0] i_reg;
    logic [31:0]                rd_st, rd_et;
    logic signed [31:0]         rd_sv, rd_ev, rd_sv2, rd_ev2, rd_spd;
    logic                       is_speed;

    assign is_speed = in_reg.channel == kte_pkg::CH_SPEED;
    assign widx     = kte_pkg::IDX_W'(in_reg.event_index);
    assign waddr    = {in_reg.channel, widx};
    assign ridx     = i_reg[kte_pkg::IDX_W-1:0];
    assign raddr    = {cmd.ch, ridx};

    always_ff @(posedge aclk) begin
        if (cmd.mem_wr) begin
            st_mem[waddr] <= in_reg.start_tick;
            et_mem[waddr] <= in_reg.end_tick;
            sv_mem[waddr] <= is_speed ? sum_base : in_reg.start_value;
            ev_mem[waddr] <= is_speed ? sum_new : in_reg.end_value;
            if (in_reg.channel == kte_pkg::CH_MOVE) begin
                sv2_mem[widx] <= in_reg.start_value_second;
                ev2_mem[widx] <= in_reg.end_value_second;
            end
            if (is_speed) spd_mem[widx] <= in_reg.start_value;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.scan_rd) begin
            rd_st  <= st_mem[raddr];
            rd_et  <= et_mem[raddr];
            rd_sv  <= sv_mem[raddr];
            rd_ev  <= ev_mem[raddr];
            rd_sv2 <= sv2_mem[ridx];
            rd_ev2 <= ev2_mem[ridx];
            rd_spd <= spd_mem[ridx];
        end
    end

    // query tick
    logic [31:0] tick_reg, tick_next;
    always_comb begin
        if (td_reg == '0)
            tick_next = (in_reg.query_seconds == '0 || bpm_reg == '0) ? 32'd0 : 32'hFFFF_FFFF;
        else if (|unit_res[kte_pkg::RES_W-1:32])
            tick_next = 32'hFFFF_FFFF;
        else
            tick_next = unit_res[31:0];
    end
    always_ff @(posedge aclk) begin
        if (cmd.tick_load) tick_reg <= tick_next;
    end

    // scan
    logic [kte_pkg::IDX_W-1:0]  cursor_reg [4];
    logic [kte_pkg::SCAN_W-1:0] cnt_ext, n_lim;

    always_comb begin
        cnt_ext = kte_pkg::SCAN_W'(cnt_reg[cmd.ch]);
        n_lim   = (cnt_ext > kte_pkg::SCAN_W'(kte_pkg::EVENT_DEPTH)) ?
                  kte_pkg::SCAN_W'(kte_pkg::EVENT_DEPTH) : cnt_ext;
    end

    always_ff @(posedge aclk) begin
        if (cmd.scan_init) i_reg <= kte_pkg::SCAN_W'(cursor_reg[cmd.ch]);
        else if (cmd.scan_adv) i_reg <= i_reg + 1'b1;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int k = 0; k < 4; k++) cursor_reg[k] <= '0;
        end else if (cmd.cursor_upd) begin
            cursor_reg[cmd.ch] <= ridx;
        end
    end

    // interpolation
    logic signed [31:0] lsv, lev, lval;
    logic [32:0]        dv, dt, dl, dv_mag, dt_mag, dl_mag;
    logic               lerp_neg, zero_len;
    logic [33:0]        qc;
    logic signed [63:0] l64, q64, lsum;

    always_comb begin
        lsv      = cmd.second ? rd_sv2 : rd_sv;
        lev      = cmd.second ? rd_ev2 : rd_ev;
        dv       = {lev[31], lev} - {lsv[31], lsv};
        dt       = {1'b0, tick_reg} - {1'b0, rd_st};
        dl       = {1'b0, rd_et} - {1'b0, rd_st};
        dv_mag   = dv[32] ? -dv : dv;
        dt_mag   = dt[32] ? -dt : dt;
        dl_mag   = dl[32] ? -dl : dl;
        lerp_neg = dv[32] ^ dt[32] ^ dl[32];
        zero_len = rd_et == rd_st;
        if (|unit_res[kte_pkg::RES_W-1:34] || (unit_res[33] && |unit_res[32:0]))
            qc = {1'b1, 33'b0};
        else
            qc = unit_res[33:0];
        l64  = {{32{lsv[31]}}, lsv};
        q64  = {30'b0, qc};
        lsum = lerp_neg ? l64 - q64 : l64 + q64;
        lval = zero_len ? lsv : sat32(lsum);
    end

    // operand selection for the shared unit
    always_comb begin
        case (cmd.opsel)
            kte_pkg::OPS_SP_MUL: begin
                opa = kte_pkg::RES_W'(md);
                opb = kte_pkg::OPB_W'(td_reg);
            end
            kte_pkg::OPS_SP_DIV: begin
                opa = unit_res;
                opb = kte_pkg::OPB_W'(bpm_reg);
            end
            kte_pkg::OPS_SP_MUL2: begin
                opa = kte_pkg::RES_W'(spd_mag);
                opb = kte_pkg::OPB_W'(dmag);
            end
            kte_pkg::OPS_Q_MUL: begin
                opa = kte_pkg::RES_W'(in_reg.query_seconds);
                opb = kte_pkg::OPB_W'(bpm_reg);
            end
            kte_pkg::OPS_Q_DIV: begin
                opa = unit_res;
                opb = kte_pkg::OPB_W'(td_reg);
            end
            kte_pkg::OPS_LP_MUL: begin
                opa = kte_pkg::RES_W'(dv_mag);
                opb = dt_mag;
            end
            kte_pkg::OPS_LP_DIV: begin
                opa = unit_res;
                opb = dl_mag;
            end
            default: begin
                opa = '0;
                opb = '0;
            end
        endcase
    end

    // last outputs
    logic signed [31:0] last_reg [6];
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int k = 0; k < 6; k++) last_reg[k] <= '0;
        end else if (cmd.lerp_fin) begin
            case (cmd.ch)
                kte_pkg::CH_MOVE: begin
                    if (cmd.second) last_reg[1] <= lval;
                    else last_reg[0] <= lval;
                end
                kte_pkg::CH_ROTATE: last_reg[2] <= lval;
                kte_pkg::CH_ALPHA:  last_reg[3] <= lval;
                kte_pkg::CH_SPEED: begin
                    last_reg[4] <= lval;
                    last_reg[5] <= rd_spd;
                end
                default: ;
            endcase
        end
    end

    // output register
    kte_pkg::kte_out_t out_reg;
    logic              m_valid_reg;

    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            out_reg.pos_x          <= last_reg[0];
            out_reg.pos_y          <= last_reg[1];
            out_reg.rotation       <= last_reg[2];
            out_reg.alpha          <= last_reg[3];
            out_reg.floor_position <= last_reg[4];
            out_reg.speed          <= last_reg[5];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) m_valid_reg <= 1'b0;
        else if (cmd.out_load) m_valid_reg <= 1'b1;
        else if (m_ready) m_valid_reg <= 1'b0;
    end

    assign m_data  = out_reg;
    assign m_valid = m_valid_reg;

    always_comb begin
        sts.is_query  = in_reg.action == kte_pkg::ACT_QUERY;
        sts.idx_ok    = 32'(in_reg.event_index) < kte_pkg::EVENT_DEPTH;
        sts.is_speed  = is_speed;
        sts.unit_busy = unit_busy;
        sts.unit_done = unit_done;
        sts.i_ge_n    = i_reg >= n_lim;
        sts.found     = tick_reg < rd_et;
        sts.out_busy  = m_valid_reg && !m_ready;
    end

endmodule

// ===== rtl/kte_ctrl.sv =====
// controller state machine sequencing writes, scans and interpolations
module kte_ctrl (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  kte_pkg::kte_sts_t   sts,
    output kte_pkg::kte_cmd_t   cmd
);
    kte_pkg::kte_state_t state_reg, state_next;
    logic [1:0]          ch_reg, ch_next;
    logic                second_reg, second_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= kte_pkg::ST_IDLE;
            ch_reg     <= kte_pkg::CH_MOVE;
            second_reg <= 1'b0;
        end else begin
            state_reg  <= state_next;
            ch_reg     <= ch_next;
            second_reg <= second_next;
        end
    end

    // next state
    always_comb begin
        state_next  = state_reg;
        ch_next     = ch_reg;
        second_next = second_reg;
        case (state_reg)
            kte_pkg::ST_IDLE:
                if (s_valid) state_next = kte_pkg::ST_DISPATCH;
            kte_pkg::ST_DISPATCH: begin
                ch_next     = kte_pkg::CH_MOVE;
                second_next = 1'b0;
                if (sts.is_query) state_next = kte_pkg::ST_Q_MUL;
                else if (!sts.idx_ok) state_next = kte_pkg::ST_IDLE;
                else if (sts.is_speed) state_next = kte_pkg::ST_SP_MUL;
                else state_next = kte_pkg::ST_WR;
            end
            kte_pkg::ST_WR:      state_next = kte_pkg::ST_IDLE;
            kte_pkg::ST_SP_MUL:  state_next = kte_pkg::ST_SP_MUL_W;
            kte_pkg::ST_SP_MUL_W:
                if (sts.unit_done) state_next = kte_pkg::ST_SP_DIV;
            kte_pkg::ST_SP_DIV:  state_next = kte_pkg::ST_SP_DIV_W;
            kte_pkg::ST_SP_DIV_W:
                if (sts.unit_done) state_next = kte_pkg::ST_SP_MUL2;
            kte_pkg::ST_SP_MUL2: state_next = kte_pkg::ST_SP_MUL2_W;
            kte_pkg::ST_SP_MUL2_W:
                if (sts.unit_done) state_next = kte_pkg::ST_SP_FIN;
            kte_pkg::ST_SP_FIN:  state_next = kte_pkg::ST_IDLE;
            kte_pkg::ST_Q_MUL:   state_next = kte_pkg::ST_Q_MUL_W;
            kte_pkg::ST_Q_MUL_W:
                if (sts.unit_done) state_next = kte_pkg::ST_Q_DIV;
            kte_pkg::ST_Q_DIV:   state_next = kte_pkg::ST_Q_DIV_W;
            kte_pkg::ST_Q_DIV_W:
                if (sts.unit_done) state_next = kte_pkg::ST_Q_TICK;
            kte_pkg::ST_Q_TICK:  state_next = kte_pkg::ST_SC_INIT;
            kte_pkg::ST_SC_INIT: state_next = kte_pkg::ST_SC_CHK;
            kte_pkg::ST_SC_CHK: begin
                if (!sts.i_ge_n) begin
                    state_next = kte_pkg::ST_SC_CMP;
                end else if (ch_reg == kte_pkg::CH_SPEED) begin
                    state_next = kte_pkg::ST_Q_OUT;
                end else begin
                    ch_next    = ch_reg + 1'b1;
                    state_next = kte_pkg::ST_SC_INIT;
                end
            end
            kte_pkg::ST_SC_CMP:
                state_next = sts.found ? kte_pkg::ST_LP_MUL : kte_pkg::ST_SC_CHK;
            kte_pkg::ST_LP_MUL:  state_next = kte_pkg::ST_LP_MUL_W;
            kte_pkg::ST_LP_MUL_W:
                if (sts.unit_done) state_next = kte_pkg::ST_LP_DIV;
            kte_pkg::ST_LP_DIV:  state_next = kte_pkg::ST_LP_DIV_W;
            kte_pkg::ST_LP_DIV_W:
                if (sts.unit_done) state_next = kte_pkg::ST_LP_FIN;
            kte_pkg::ST_LP_FIN: begin
                // move events interpolate x, then y from the same entry
                if (ch_reg == kte_pkg::CH_MOVE && !second_reg) begin
                    second_next = 1'b1;
                    state_next  = kte_pkg::ST_LP_MUL;
                end else begin
                    second_next = 1'b0;
                    if (ch_reg == kte_pkg::CH_SPEED) begin
                        state_next = kte_pkg::ST_Q_OUT;
                    end else begin
                        ch_next    = ch_reg + 1'b1;
                        state_next = kte_pkg::ST_SC_INIT;
                    end
                end
            end
            kte_pkg::ST_Q_OUT:
                if (!sts.out_busy) state_next = kte_pkg::ST_IDLE;
            default: state_next = kte_pkg::ST_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        cmd            = '0;
        cmd.uop        = kte_pkg::UOP_MUL;
        cmd.opsel      = kte_pkg::OPS_SP_MUL;
        cmd.ch         = ch_reg;
        cmd.second     = second_reg;
        s_ready        = 1'b0;
        case (state_reg)
            kte_pkg::ST_IDLE: begin
                s_ready     = 1'b1;
                cmd.capture = s_valid;
            end
            kte_pkg::ST_WR:  cmd.mem_wr = 1'b1;
            kte_pkg::ST_SP_MUL: begin
                cmd.unit_start = 1'b1;
                cmd.opsel      = kte_pkg::OPS_SP_MUL;
            end
            kte_pkg::ST_SP_DIV: begin
                cmd.unit_start = 1'b1;
                cmd.uop        = kte_pkg::UOP_DIV;
                cmd.opsel      = kte_pkg::OPS_SP_DIV;
            end
            kte_pkg::ST_SP_MUL2: begin
                cmd.unit_start = 1'b1;
                cmd.opsel      = kte_pkg::OPS_SP_MUL2;
            end
            kte_pkg::ST_SP_FIN: begin
                cmd.mem_wr  = 1'b1;
                cmd.sum_upd = 1'b1;
            end
            kte_pkg::ST_Q_MUL: begin
                cmd.unit_start = 1'b1;
                cmd.opsel      = kte_pkg::OPS_Q_MUL;
            end
            kte_pkg::ST_Q_DIV: begin
                cmd.unit_start = 1'b1;
                cmd.uop        = kte_pkg::UOP_DIV;
                cmd.opsel      = kte_pkg::OPS_Q_DIV;
            end
            kte_pkg::ST_Q_TICK:  cmd.tick_load = 1'b1;
            kte_pkg::ST_SC_INIT: cmd.scan_init = 1'b1;
            kte_pkg::ST_SC_CHK:  cmd.scan_rd = !sts.i_ge_n;
            kte_pkg::ST_SC_CMP: begin
                cmd.cursor_upd = sts.found;
                cmd.scan_adv   = !sts.found;
            end
            kte_pkg::ST_LP_MUL: begin
                cmd.unit_start = 1'b1;
                cmd.opsel      = kte_pkg::OPS_LP_MUL;
            end
            kte_pkg::ST_LP_DIV: begin
                cmd.unit_start = 1'b1;
                cmd.uop        = kte_pkg::UOP_DIV;
                cmd.opsel      = kte_pkg::OPS_LP_DIV;
            end
            kte_pkg::ST_LP_FIN: cmd.lerp_fin = 1'b1;
            kte_pkg::ST_Q_OUT:  cmd.out_load = !sts.out_busy;
            default: ;
        endcase
    end

    assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.unit_start |-> !sts.unit_busy)
        else $error("arith unit started while busy");

    assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.out_load |-> !sts.out_busy)
        else $error("result overwritten before it was taken");

    assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.mem_wr |-> !sts.is_query)
        else $error("table written during a query");

    assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.scan_rd |-> !sts.i_ge_n)
        else $error("table read past the event count");

endmodule

// ===== rtl/keyframe_track_evaluator.sv =====
// top level of the keyframe track evaluator
// Usage:
//   s_valid/s_ready/s_data take one item: a table write (action 0) or a
//   query (action 1). Writes give no result; each query gives one result
//   item on m_valid/m_ready/m_data with x, y, rotation, alpha, floor and speed.
//   cfg_valid/cfg_ready/cfg_index/cfg_data write the tempo, tick divisor and
//   the four event counts; cfg_ready is always high. Write them while idle.
// Timing:
//   one item is worked on at a time; s_ready is high only between items.
//   A plain table write is stored directly. A speed write multiplies the
//   duration by the tick divisor, divides by the tempo, then multiplies by
//   the speed. A query computes the tick, scans the channels and runs up to
//   five interpolations. The shared bit-serial multiply/divide unit does one
//   bit per cycle, 33 steps per multiply and 66 per divide.
// Reset and stalls:
//   reset clears cursors, floor sum, last outputs and config to defaults;
//   table contents stay undefined until written. A query result waits in the
//   output register; a following query stalls at its end until it is taken.
module keyframe_track_evaluator (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_valid,
    output logic                            s_ready,
    input  kte_pkg::kte_in_t                s_data,
    output logic                            m_valid,
    input  logic                            m_ready,
    output kte_pkg::kte_out_t               m_data,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [kte_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [31:0]                     cfg_data
);
    kte_pkg::kte_cmd_t cmd;
    kte_pkg::kte_sts_t sts;

    assign cfg_ready = 1'b1;

    kte_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .sts     (sts),
        .cmd     (cmd)
    );

    kte_dp u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_data    (s_data),
        .cfg_we    (cfg_valid && cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cmd       (cmd),
        .sts       (sts),
        .m_data    (m_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready)
    );

endmodule
